// ===== rtl/ipv6p_pkg.sv =====
// Shared types and constants for the IPv6 address text parser.
// Used by ipv6p_char_step, ipv6p_gap_pack and ipv6_address_text_parser_top.
package ipv6p_pkg;

  localparam int GROUPS      = 8;
  localparam int GROUP_W     = 16;
  localparam int GROUP_IDX_W = $clog2(GROUPS);
  localparam int CNT_W       = GROUP_IDX_W + 1;
  localparam int ADDR_HALF_W = 64;
  localparam int OUT_DATA_W  = 136;

  localparam logic [7:0] CHAR_COLON = 8'h3a;

  typedef enum logic [2:0] {
    ST_OK          = 3'd0,
    ST_BAD_CHAR    = 3'd1,
    ST_OVERFLOW    = 3'd2,
    ST_BAD_COLON   = 3'd3,
    ST_GROUP_COUNT = 3'd4
  } status_t;

  typedef enum logic [1:0] {
    RUN_NONE = 2'd0,
    RUN_ONE  = 2'd1,
    RUN_TWO  = 2'd2
  } colon_run_t;

  typedef logic [GROUP_W-1:0] group_t;
  typedef logic [GROUPS-1:0][GROUP_W-1:0] store_t;

  // Snapshot of a finished text, handed from the character stage to the packer.
  typedef struct packed {
    status_t            status;
    store_t             store;
    logic [CNT_W-1:0]   cnt;
    logic [CNT_W-1:0]   gap;
    logic               seen;
  } finish_t;

endpackage

// ===== rtl/ipv6_address_text_parser_top.sv =====
// Top level of the IPv6 address text parser.
// Instantiates ipv6p_char_step and ipv6p_gap_pack; depends on ipv6p_pkg.
//
// Usage:
//   The slave channel takes one ASCII character of an address text per word,
//   with s_tlast marking the final character. The master channel gives one
//   word per text: a status code and the 128-bit address, which is zero on
//   any error.
//   Throughput is one character per cycle while s_tready is high; each
//   character updates the group accumulator and store in the cycle it is accepted.
//   After the last character is accepted, the result word passes the finish
//   snapshot register and then the gap-expansion output register.
//   When the receiver stalls, the result waits in the output register and one
//   more finished text can wait behind it; while that finished text is held
//   back, s_tready is low and no character is taken until the output register
//   frees.
//   Reset (rst, synchronous) clears the parsing state and both valid flags;
//   nothing else needs clearing.
module ipv6_address_text_parser_top import ipv6p_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] text_char
  input  logic                  s_tlast,   // last_char
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata    // [2:0] parse_status, [66:3] addr_high,
                                           // [130:67] addr_low, rest zero
);

  logic    accept;
  logic    fin_valid;
  logic    fin_ready;
  finish_t fin;

  assign s_tready = !fin_valid || fin_ready;
  assign accept   = s_tvalid && s_tready;

  ipv6p_char_step u_step (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .text_char (s_tdata),
    .last_char (s_tlast),
    .fin_take  (fin_ready),
    .fin_valid (fin_valid),
    .fin       (fin)
  );

  ipv6p_gap_pack u_pack (
    .clk       (clk),
    .rst       (rst),
    .fin_valid (fin_valid),
    .fin       (fin),
    .fin_ready (fin_ready),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata)
  );

  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    fin_valid && !fin_ready |-> !s_tready)
    else $error("input accepted while a finished text is blocked");

endmodule

// ===== rtl/ipv6p_char_step.sv =====
// Per-character parsing state: hex group accumulation, colon tracking and group store.
// Produces a finish snapshot on the last character. Depends on ipv6p_pkg.
module ipv6p_char_step import ipv6p_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       accept,
  input  logic [7:0] text_char,
  input  logic       last_char,
  input  logic       fin_take,
  output logic       fin_valid,
  output finish_t    fin
);

  group_t           acc, acc_next;
  logic [CNT_W-1:0] cnt, cnt_next;
  colon_run_t       run, run_next;
  logic [CNT_W-1:0] gap, gap_next;
  logic             seen, seen_next;
  status_t          err, err_next;
  logic [1:0]       pos, pos_next;
  store_t           store, store_next;

  logic                   close_en;
  logic                   wr_en;
  logic [GROUP_IDX_W-1:0] wr_idx;
  group_t                 wr_data;
  logic [4:0]             hex;

  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [7:0] d;
    d = 8'h00;
    case (c) inside
      ["0":"9"]: begin
        d = c - 8'h30;
        return {1'b1, d[3:0]};
      end
      ["a":"f"]: begin
        d = c - 8'h57;
        return {1'b1, d[3:0]};
      end
      ["A":"F"]: begin
        d = c - 8'h37;
        return {1'b1, d[3:0]};
      end
      default: return 5'd0;
    endcase
  endfunction

  always_comb begin
    acc_next  = acc;
    cnt_next  = cnt;
    run_next  = run;
    gap_next  = gap;
    seen_next = seen;
    err_next  = err;
    pos_next  = pos;
    close_en  = 1'b0;
    wr_en     = 1'b0;
    wr_idx    = cnt[GROUP_IDX_W-1:0];
    wr_data   = acc;
    hex       = hex_decode(text_char);

    // Once an error is recorded the text is only counted until its end.
    if (err == ST_OK) begin
      if (text_char == CHAR_COLON) begin
        unique case (run)
          RUN_NONE: begin
            if (pos != 2'd0) close_en = 1'b1;
            run_next = RUN_ONE;
          end
          RUN_ONE: begin
            if (seen) begin
              err_next = ST_BAD_COLON;
            end else begin
              seen_next = 1'b1;
              gap_next  = cnt;
              run_next  = RUN_TWO;
            end
          end
          default: err_next = ST_BAD_COLON;
        endcase
      end else if (run == RUN_ONE && pos == 2'd1) begin
        // A leading colon must be followed by a second one.
        err_next = ST_BAD_COLON;
      end else if (!hex[4]) begin
        err_next = ST_BAD_CHAR;
      end else begin
        if (acc[GROUP_W-1:GROUP_W-4] != 4'd0) begin
          err_next = ST_OVERFLOW;
        end else begin
          acc_next = {acc[GROUP_W-5:0], hex[3:0]};
        end
        run_next = RUN_NONE;
      end
    end
    if (pos != 2'd2) pos_next = pos + 2'd1;

    if (last_char && err_next == ST_OK) begin
      if (run_next == RUN_ONE) begin
        err_next = ST_BAD_COLON;
      end else if (run_next == RUN_NONE) begin
        close_en = 1'b1;
      end
    end

    // The closed group includes a digit taken in this same cycle.
    if (close_en) begin
      if (cnt_next >= CNT_W'(GROUPS)) begin
        err_next = ST_GROUP_COUNT;
      end else begin
        wr_en    = 1'b1;
        wr_idx   = cnt_next[GROUP_IDX_W-1:0];
        wr_data  = acc_next;
        cnt_next = cnt_next + CNT_W'(1);
        acc_next = '0;
      end
    end

    // The gap must stand for at least one group; without it all groups are needed.
    if (last_char && err_next == ST_OK) begin
      if (seen_next && cnt_next > CNT_W'(GROUPS - 1)) err_next = ST_GROUP_COUNT;
      if (!seen_next && cnt_next != CNT_W'(GROUPS)) err_next = ST_GROUP_COUNT;
    end

    store_next = store;
    if (wr_en) store_next[wr_idx] = wr_data;
  end

  // Group store entries past the count are never read, so the store needs no reset.
  always_ff @(posedge clk) begin
    if (accept && wr_en) store[wr_idx] <= wr_data;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc  <= '0;
      cnt  <= '0;
      run  <= RUN_NONE;
      gap  <= '0;
      seen <= 1'b0;
      err  <= ST_OK;
      pos  <= 2'd0;
    end else if (accept) begin
      if (last_char) begin
        acc  <= '0;
        cnt  <= '0;
        run  <= RUN_NONE;
        gap  <= '0;
        seen <= 1'b0;
        err  <= ST_OK;
        pos  <= 2'd0;
      end else begin
        acc  <= acc_next;
        cnt  <= cnt_next;
        run  <= run_next;
        gap  <= gap_next;
        seen <= seen_next;
        err  <= err_next;
        pos  <= pos_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      fin_valid <= 1'b0;
    end else if (accept && last_char) begin
      fin_valid <= 1'b1;
    end else if (fin_take) begin
      fin_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && last_char) begin
      fin.status <= err_next;
      fin.store  <= store_next;
      fin.cnt    <= cnt_next;
      fin.gap    <= gap_next;
      fin.seen   <= seen_next;
    end
  end

  a_cnt_range: assert property (@(posedge clk) disable iff (rst)
    cnt <= CNT_W'(GROUPS))
    else $error("group count beyond the address size");

  a_gap_range: assert property (@(posedge clk) disable iff (rst)
    gap <= cnt)
    else $error("gap start lies past the stored groups");

  a_fin_load: assert property (@(posedge clk) disable iff (rst)
    accept && last_char |=> fin_valid)
    else $error("last character did not produce a finish snapshot");

endmodule

// ===== rtl/ipv6p_gap_pack.sv =====
// Expands the '::' gap of a finished text into the 128-bit address and holds the result word.
// Depends on ipv6p_pkg.
module ipv6p_gap_pack import ipv6p_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  fin_valid,
  input  finish_t               fin,
  output logic                  fin_ready,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [OUT_DATA_W-1:0] m_tdata
);

  store_t           addr;
  logic [CNT_W-1:0] tail;
  logic [CNT_W-1:0] base;
  logic [CNT_W-1:0] jj;
  status_t          status_q;
  logic [2*ADDR_HALF_W-1:0] addr_q;

  always_comb begin
    tail = fin.cnt - fin.gap;
    base = CNT_W'(GROUPS) - tail;
    jj   = '0;
    for (int j = 0; j < GROUPS; j++) begin
      jj = CNT_W'(j);
      if (fin.status != ST_OK) begin
        addr[j] = '0;
      end else if (!fin.seen || jj < fin.gap) begin
        addr[j] = fin.store[j];
      end else if (jj >= base) begin
        addr[j] = fin.store[GROUP_IDX_W'(fin.gap + jj - base)];
      end else begin
        addr[j] = '0;
      end
    end
  end

  assign fin_ready = !m_tvalid || m_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (fin_ready) begin
      m_tvalid <= fin_valid;
    end
  end

  // Group 0 is the most significant group of the high half.
  always_ff @(posedge clk) begin
    if (fin_valid && fin_ready) begin
      status_q <= fin.status;
      for (int j = 0; j < GROUPS; j++) begin
        addr_q[(GROUPS-1-j)*GROUP_W +: GROUP_W] <= addr[j];
      end
    end
  end

  assign m_tdata = {5'd0, addr_q[ADDR_HALF_W-1:0], addr_q[2*ADDR_HALF_W-1:ADDR_HALF_W],
                    status_q};

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[2:0] != ST_OK |-> m_tdata[OUT_DATA_W-1:3] == '0)
    else $error("error result carries a nonzero address");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> m_tdata[2:0] <= ST_GROUP_COUNT)
    else $error("result status outside the defined codes");

endmodule

// ===== bench/ipv6_address_text_parser_checker.sv =====
// Checker for the IPv6 address text parser: watches both stream channels,
// predicts each result word from the accepted characters and compares.
// Depends on ipv6p_pkg for the status and colon-run codes.
`timescale 1ns / 100ps

module ipv6_address_text_parser_checker import ipv6p_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  input  logic                  s_tready,
  input  logic [7:0]            s_tdata,   // [7:0] text_char
  input  logic                  s_tlast,   // last_char
  input  logic                  m_tvalid,
  input  logic                  m_tready,
  input  logic [OUT_DATA_W-1:0] m_tdata,   // [2:0] parse_status, [66:3] addr_high,
                                           // [130:67] addr_low
  output int                    fail_count,
  output int                    results_outstanding
);

  typedef struct packed {
    status_t     status;
    logic [63:0] addr_high;
    logic [63:0] addr_low;
  } addr_result_t;

  addr_result_t expected_addr_q[$];
  int           mismatches = 0;

  // Parser state as the block should hold it.
  logic [7:0]  store_bytes [16];
  logic [15:0] group_value;
  logic [4:0]  stored_count;
  colon_run_t  colon_count;
  logic [4:0]  gap_at;
  logic        gap_found;
  status_t     first_error;
  logic [1:0]  chars_seen;

  task automatic clear_parser();
    foreach (store_bytes[k]) store_bytes[k] = 8'h00;
    group_value  = '0;
    stored_count = '0;
    colon_count  = RUN_NONE;
    gap_at       = '0;
    gap_found    = 1'b0;
    first_error  = ST_OK;
    chars_seen   = '0;
  endtask

  task automatic note_error(input status_t code);
    if (first_error == ST_OK) first_error = code;
  endtask

  task automatic close_group();
    if (stored_count >= 5'd16) begin
      note_error(ST_GROUP_COUNT);
    end else begin
      store_bytes[stored_count]        = group_value[15:8];
      store_bytes[stored_count + 5'd1] = group_value[7:0];
      stored_count = stored_count + 5'd2;
      group_value  = '0;
    end
  endtask

  // Advances the parser by one character and queues the address word that a
  // final character produces.
  task automatic parse_text_char(input logic [7:0] ch, input logic last);
    logic [3:0]   digit;
    logic         digit_ok;
    logic [19:0]  widened;
    logic [7:0]   addr_byte;
    int           tail;
    int           base;
    addr_result_t res;
    if (first_error == ST_OK) begin
      if (ch == CHAR_COLON) begin
        case (colon_count)
          RUN_NONE: begin
            if (chars_seen != 2'd0) close_group();
            colon_count = RUN_ONE;
          end
          RUN_ONE: begin
            if (gap_found) begin
              note_error(ST_BAD_COLON);
            end else begin
              gap_found   = 1'b1;
              gap_at      = stored_count;
              colon_count = RUN_TWO;
            end
          end
          default: note_error(ST_BAD_COLON);
        endcase
      end else if (colon_count == RUN_ONE && chars_seen == 2'd1) begin
        // A lone leading colon must be followed by a second one.
        note_error(ST_BAD_COLON);
      end else begin
        digit_ok = 1'b1;
        digit    = '0;
        if (ch >= "0" && ch <= "9") digit = 4'(ch - "0");
        else if (ch >= "a" && ch <= "f") digit = 4'(ch - "a" + 8'd10);
        else if (ch >= "A" && ch <= "F") digit = 4'(ch - "A" + 8'd10);
        else digit_ok = 1'b0;
        if (!digit_ok) begin
          note_error(ST_BAD_CHAR);
        end else begin
          widened = {group_value, digit};
          if (widened > 20'hffff) note_error(ST_OVERFLOW);
          else group_value = widened[15:0];
          colon_count = RUN_NONE;
        end
      end
    end
    if (chars_seen < 2'd2) chars_seen = chars_seen + 2'd1;

    if (!last) return;

    if (first_error == ST_OK) begin
      if (colon_count == RUN_ONE) note_error(ST_BAD_COLON);
      else if (colon_count == RUN_NONE) close_group();
    end
    if (first_error == ST_OK) begin
      // A gap has to stand for at least one group.
      if (gap_found && stored_count > 5'd14) note_error(ST_GROUP_COUNT);
      if (!gap_found && stored_count != 5'd16) note_error(ST_GROUP_COUNT);
    end

    tail = int'(stored_count) - int'(gap_at);
    base = 16 - tail;
    res.status    = first_error;
    res.addr_high = '0;
    res.addr_low  = '0;
    for (int k = 0; k < 16; k++) begin
      addr_byte = 8'h00;
      if (first_error == ST_OK) begin
        if (!gap_found || k < gap_at) addr_byte = store_bytes[k];
        else if (k >= base) addr_byte = store_bytes[(gap_at + k - base) & 15];
      end
      if (k < 8) res.addr_high = {res.addr_high[55:0], addr_byte};
      else res.addr_low = {res.addr_low[55:0], addr_byte};
    end
    expected_addr_q.push_back(res);
    clear_parser();
  endtask

  always @(posedge clk) begin : watch
    addr_result_t want;
    if (rst) begin
      clear_parser();
      expected_addr_q.delete();
      results_outstanding <= 0;
      fail_count <= 0;
    end else begin
      // A result word comes out only after its last character has passed the finish
      // snapshot and output registers, so the output side is checked before this edge's character is applied.
      if (m_tvalid && m_tready) begin
        if (expected_addr_q.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result word with none expected: %h", $time, m_tdata);
          mismatches++;
        end else begin
          want = expected_addr_q.pop_front();
          if (m_tdata[2:0] !== want.status || m_tdata[66:3] !== want.addr_high ||
              m_tdata[130:67] !== want.addr_low) begin
            if (mismatches < 10)
              $display("%0t: mismatch status exp %0d got %0d, high exp %h got %h, low exp %h got %h",
                       $time, want.status, m_tdata[2:0], want.addr_high, m_tdata[66:3],
                       want.addr_low, m_tdata[130:67]);
            mismatches++;
          end
        end
      end
      if (s_tvalid && s_tready) parse_text_char(s_tdata, s_tlast);
      results_outstanding <= expected_addr_q.size();
      fail_count <= mismatches;
    end
  end

endmodule

// ===== bench/ipv6_address_text_parser_top_tb.sv =====
// Testbench top for the IPv6 address text parser: drives address texts one
// character per word, stalls the result side at random and gives the verdict.
// Depends on ipv6p_pkg and ipv6_address_text_parser_checker.
`timescale 1ns / 100ps

module ipv6_address_text_parser_top_tb;
  import ipv6p_pkg::*;

  logic                  clk;
  logic                  rst = 1'b1;
  logic                  s_tvalid = 1'b0;
  logic                  s_tready;
  logic [7:0]            s_tdata = 8'h00;
  logic                  s_tlast = 1'b0;
  logic                  m_tvalid;
  logic                  m_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_tdata;

  int   fail_count;
  int   results_outstanding;
  logic no_idle = 1'b0;
  int   chars_sent = 0;
  int   pick;

  logic [7:0] text_buf[$];

  ipv6_address_text_parser_top u_dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  ipv6_address_text_parser_checker u_checker (
    .clk                 (clk),
    .rst                 (rst),
    .s_tvalid            (s_tvalid),
    .s_tready            (s_tready),
    .s_tdata             (s_tdata),
    .s_tlast             (s_tlast),
    .m_tvalid            (m_tvalid),
    .m_tready            (m_tready),
    .m_tdata             (m_tdata),
    .fail_count          (fail_count),
    .results_outstanding (results_outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    m_tready <= no_idle ? 1'b1 : ($urandom_range(0, 99) >= 18);
  end

  function automatic logic [7:0] hex_char(input logic [3:0] nib);
    if (nib < 4'd10) return 8'h30 + nib;
    return ($urandom_range(0, 1) ? 8'h41 : 8'h61) + nib - 8'd10;
  endfunction

  task automatic push_group();
    int n_digits;
    n_digits = $urandom_range(1, 4);
    // Now and then an extra leading zero, which is still a valid group.
    if ($urandom_range(0, 9) == 0) text_buf.push_back("0");
    repeat (n_digits) text_buf.push_back(hex_char(4'($urandom_range(0, 15))));
  endtask

  task automatic build_address();
    int n_total;
    int n_head;
    text_buf.delete();
    if ($urandom_range(0, 3) == 0) begin
      for (int g = 0; g < 8; g++) begin
        if (g != 0) text_buf.push_back(CHAR_COLON);
        push_group();
      end
    end else begin
      n_total = $urandom_range(0, 7);
      n_head  = $urandom_range(0, n_total);
      for (int g = 0; g < n_head; g++) begin
        if (g != 0) text_buf.push_back(CHAR_COLON);
        push_group();
      end
      text_buf.push_back(CHAR_COLON);
      text_buf.push_back(CHAR_COLON);
      for (int g = 0; g < n_total - n_head; g++) begin
        if (g != 0) text_buf.push_back(CHAR_COLON);
        push_group();
      end
    end
  endtask

  task automatic corrupt_text();
    int pos;
    pos = $urandom_range(0, text_buf.size() - 1);
    case ($urandom_range(0, 5))
      0: text_buf[pos] = 8'($urandom_range(0, 255));
      1: text_buf.insert(pos, CHAR_COLON);
      2: text_buf.delete(pos);
      3: begin
        text_buf.push_back(CHAR_COLON);
        push_group();
      end
      4: text_buf.insert(pos, hex_char(4'($urandom_range(0, 15))));
      default: text_buf.insert(0, CHAR_COLON);
    endcase
  endtask

  task automatic send_char(input logic [7:0] ch, input logic last);
    if (!no_idle && $urandom_range(0, 99) < 18) begin
      s_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(0, 99) < 18);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= ch;
    s_tlast  <= last;
    do @(posedge clk); while (!s_tready);
    chars_sent++;
  endtask

  task automatic send_text();
    foreach (text_buf[i]) send_char(text_buf[i], i == text_buf.size() - 1);
  endtask

  task automatic send_string(input string s);
    text_buf.delete();
    for (int i = 0; i < s.len(); i++) text_buf.push_back(s[i]);
    send_text();
  endtask

  // Holds the sender off until every predicted result word has come out.
  task automatic drain_results();
    s_tvalid <= 1'b0;
    @(posedge clk);
    while (results_outstanding != 0) @(posedge clk);
  endtask

  initial begin
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_string("::");
    send_string(":1");
    send_string("1:");
    send_string(":::");
    send_string("fFfF0");
    send_string("1::2::");
    send_string("1");
    text_buf.delete();
    text_buf.push_back(8'h00);
    text_buf.push_back(8'hff);
    send_text();
    drain_results();

    while (chars_sent < 1050) begin
      no_idle <= (chars_sent >= 450 && chars_sent < 650);
      pick = $urandom_range(0, 99);
      if (pick < 10) begin
        text_buf.delete();
        repeat ($urandom_range(1, 6)) text_buf.push_back(8'($urandom_range(0, 255)));
      end else begin
        build_address();
        if (pick < 38) corrupt_text();
      end
      send_text();
      if ($urandom_range(0, 19) == 0) drain_results();
    end
    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("*** FAILED ***");
    $finish;
  end

endmodule
